>>> sv/bsmt_pkg.sv
// Shared types and constants for the bounded set membership table.
// No dependencies; imported by the controller, datapath and top level.
package bsmt_pkg;

  // Default storage depth and field widths
  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned CAP_W           = 5;
  localparam int unsigned CNT_OUT_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  // Operation codes; the unused code behaves as a look up
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // register request and match vector
    logic apply;    // update the store and load the result register
  } bsmt_cmd_t;

endpackage

>>> sv/bsmt_ctrl.sv
// Controller for the bounded set membership table: request sequencing.
// Depends on bsmt_pkg for the command struct.
module bsmt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bsmt_pkg::bsmt_cmd_t cmd
);
  import bsmt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // Result register can take a new result when empty or being drained
  assign slot_free = !out_valid_r || out_ready;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.capture   = 1'b0;
    cmd.apply     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_APPLY;
        end
      end
      S_APPLY: begin
        if (slot_free) begin
          cmd.apply     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> sv/bsmt_dpath.sv
// Datapath for the bounded set membership table: entry registers, parallel
// match, packed shift on remove, count, capacity register and result register.
// Depends on bsmt_pkg for widths, op codes and the command struct.
module bsmt_dpath #(
  parameter int unsigned MAX_ENTRIES = bsmt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bsmt_pkg::bsmt_cmd_t                  cmd,
  input  logic [bsmt_pkg::OP_W-1:0]            in_operation,
  input  logic signed [bsmt_pkg::VAL_W-1:0]    in_element_value,
  input  logic                                 cfg_we,
  input  logic [bsmt_pkg::CAP_W-1:0]           cfg_data,
  output logic                                 out_was_present,
  output logic                                 out_status,
  output logic [bsmt_pkg::CNT_OUT_W-1:0]       out_member_count,
  output logic                                 out_is_empty,
  output logic                                 out_is_full
);
  import bsmt_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned WIDE_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned WW     = (WIDE_W > CNT_OUT_W) ? WIDE_W : CNT_OUT_W;

  logic [VAL_W-1:0]     entry_r   [MAX_ENTRIES];
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CAP_W-1:0]     cap_r;
  logic [OP_W-1:0]      op_r;
  logic [VAL_W-1:0]     val_r;
  logic [MAX_ENTRIES-1:0] match_r, match_nxt, shift_en;

  logic             present, full_now, do_insert, do_remove, reject;
  logic [WW-1:0]    count_w, count_nxt_w, cap_w, max_w, eff_cap_w;

  // Compare every live entry against the incoming value
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_nxt[i] = (entry_r[i] == in_element_value) && (CNT_W'(i) < count_r);
    end
  end

  // Entry i takes its upper neighbor when the removed entry sits at or below it
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      shift_en[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        shift_en[i] = shift_en[i] | match_r[j];
      end
    end
  end

  // Effective capacity and update decisions
  assign count_w   = WW'(count_r);
  assign cap_w     = WW'(cap_r);
  assign max_w     = WW'(MAX_ENTRIES);
  assign eff_cap_w = (cap_w > max_w) ? max_w : cap_w;
  assign present   = |match_r;
  assign full_now  = (count_w >= eff_cap_w);

  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    reject    = 1'b0;
    case (op_r)
      OP_INSERT: begin
        do_insert = !present && !full_now;
        reject    = !present && full_now;
      end
      OP_REMOVE: do_remove = present;
      default: begin
        do_insert = 1'b0;
        do_remove = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign count_nxt_w = WW'(count_nxt);

  // Capture the request and its match vector
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      val_r   <= in_element_value;
      match_r <= match_nxt;
    end
  end

  // Append on insert, shift down on remove
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (do_insert && (count_r == CNT_W'(i))) begin
          entry_r[i] <= val_r;
        end else if (do_remove && shift_en[i] && (i + 1 < MAX_ENTRIES)) begin
          entry_r[i] <= entry_r[(i + 1) % MAX_ENTRIES];
        end
      end
    end
  end

  // Hold count and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      if (cmd.apply) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_was_present  <= present;
      out_status       <= reject;
      out_member_count <= count_nxt_w[CNT_OUT_W-1:0];
      out_is_empty     <= (count_nxt == '0);
      out_is_full      <= (count_nxt_w >= eff_cap_w);
    end
  end

endmodule

>>> sv/bounded_set_membership_table.sv
// Top level of the bounded set membership table: controller plus datapath.
// Depends on bsmt_pkg, bsmt_ctrl and bsmt_dpath.
//
//   channel  direction  handshake             payload
//   in_      request    in_valid / in_ready   in_operation, in_element_value
//   out_     result     out_valid / out_ready was_present, status, member_count,
//                                             is_empty, is_full
//   cfg_     write      cfg_valid / cfg_ready cfg_data (capacity in use)
//
// On acceptance of a request all entries are compared against the value at
// once and the match vector is registered; in the apply step the entries are
// appended or shifted and the result register is loaded. A waiting result
// stalls only the apply step. Reset clears the count and sets the capacity to
// 10; the entries are not cleared. cfg_ready is always high.
module bounded_set_membership_table #(
  parameter int unsigned MAX_ENTRIES = bsmt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bsmt_pkg::OP_W-1:0]          in_operation,
  input  logic signed [bsmt_pkg::VAL_W-1:0]  in_element_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_was_present,
  output logic                               out_status,
  output logic [bsmt_pkg::CNT_OUT_W-1:0]     out_member_count,
  output logic                               out_is_empty,
  output logic                               out_is_full,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bsmt_pkg::CAP_W-1:0]         cfg_data
);
  import bsmt_pkg::*;

  bsmt_cmd_t cmd;

  assign cfg_ready = 1'b1;

  bsmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bsmt_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_operation),
    .in_element_value (in_element_value),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .out_was_present  (out_was_present),
    .out_status       (out_status),
    .out_member_count (out_member_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full)
  );

endmodule
